/* src/sog_pkg.sv */
// Shared types and constants of the shuffle order generator.
package sog_pkg;

    // Bits of the LFSR state taken for each random draw
    localparam int DRAW_W = 15;
    // Width of the step counter of the modulo unit (counts DRAW_W down to 0)
    localparam int STEP_W = 4;

    localparam logic [31:0] LFSR_TAPS  = 32'hD000_0001;
    localparam logic [31:0] SEED_RESET = 32'h0000_0001;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [0:0] {
        REG_SHUFFLE_ENABLE = 1'b0,
        REG_RANDOM_SEED    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [8:0] list_length;
        logic [7:0] current_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] next_index;
        logic       reshuffled;
    } out_item_t;

endpackage

/* src/shuffle_order_generator.sv */
// Top level of the shuffle order generator: request handling, table rebuild, APB registers.
// A sequential item passes from accept through EMIT into the output register; a shuffled item
//   with no rebuild first reads its slot in LOOKUP; a rebuild of N entries first runs N fill
//   steps and N-1 swaps (draw, 15 modulo steps and a done step, two writes on one write port).
// One item at a time: the next request is taken once the last result enters the output register.
// Reset: synchronous, active low; stored length, slot, seed and LFSR return to reset values.
// The order table has no reset; a rebuild always fills it before it is read.
module shuffle_order_generator #(
    parameter int LIST_MAX = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  sog_pkg::in_item_t s_payload,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output sog_pkg::out_item_t m_payload,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(LIST_MAX);
    localparam int LEN_W = IDX_W + 1;
    localparam int CMP_W = (LEN_W > 9) ? LEN_W : 9;

    // One-hot sequencer
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_FILL   = 8'b0000_0010,
        ST_DRAW   = 8'b0000_0100,
        ST_MOD    = 8'b0000_1000,
        ST_WR_I   = 8'b0001_0000,
        ST_WR_R   = 8'b0010_0000,
        ST_LOOKUP = 8'b0100_0000,
        ST_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic        shuffle_en_reg;
    logic [31:0] seed_reg;
    logic [31:0] lfsr_reg;
    logic        cfg_wr;

    // shuffle state
    logic [LEN_W-1:0] stored_len_reg;
    logic [LEN_W-1:0] next_slot_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] r_reg;
    logic [IDX_W-1:0] t_reg;

    // pending result
    logic       from_table_reg;
    logic       fresh_reg;
    logic [7:0] seq_idx_reg;

    // output register
    logic               m_valid_reg;
    sog_pkg::out_item_t m_payload_reg;
    logic               out_free;

    // request decode
    logic [CMP_W-1:0] len_wide;
    logic [LEN_W-1:0] len_c;
    logic [8:0]       cur_inc;
    logic [7:0]       seq_idx;
    logic             shuffle_req;
    logic             need_rebuild;
    logic             in_acc;

    // LFSR step and modulo unit
    logic [31:0]      lfsr_step;
    logic             mod_start;
    logic             mod_done;
    logic [LEN_W-1:0] mod_rem;
    logic [LEN_W-1:0] span;
    logic [IDX_W-1:0] swap_addr;

    // table RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [IDX_W-1:0] ram_rdata;

    // ------------------------------------------------------------------
    // APB: zero wait states, writes land on the access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (sog_pkg::reg_idx_t'(paddr[2]))
            sog_pkg::REG_SHUFFLE_ENABLE: prdata = {31'd0, shuffle_en_reg};
            sog_pkg::REG_RANDOM_SEED:    prdata = seed_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode: clamp the length, form the sequential answer
    // ------------------------------------------------------------------
    always_comb begin
        len_wide = CMP_W'(s_payload.list_length);
        if (len_wide > CMP_W'(LIST_MAX)) begin
            len_c = LEN_W'(LIST_MAX);
        end else begin
            len_c = LEN_W'(len_wide);
        end
        cur_inc = {1'b0, s_payload.current_index} + 9'd1;
        // wrap to zero once the increment runs off the list
        if (CMP_W'(cur_inc) >= CMP_W'(len_c)) begin
            seq_idx = 8'd0;
        end else begin
            seq_idx = cur_inc[7:0];
        end
        shuffle_req  = shuffle_en_reg && (len_c > LEN_W'(2));
        need_rebuild = (len_c != stored_len_reg) || (next_slot_reg >= stored_len_reg);
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Random draw: Galois LFSR, one step per swap
    // ------------------------------------------------------------------
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? sog_pkg::LFSR_TAPS : 32'd0);
    assign mod_start = (state_reg == ST_DRAW);
    assign span      = stored_len_reg - LEN_W'(cnt_reg);
    assign swap_addr = cnt_reg + IDX_W'(mod_rem);

    sog_mod #(
        .DIV_W(LEN_W)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (lfsr_step[sog_pkg::DRAW_W-1:0]),
        .divisor   (span),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // ------------------------------------------------------------------
    // Order table: one write and one read per cycle, read data registered.
    // The sequencer never reads an entry in the cycle it is written.
    // ------------------------------------------------------------------
    sog_ram #(
        .WIDTH(IDX_W),
        .DEPTH(LIST_MAX)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = cnt_reg;
        ram_re    = 1'b0;
        ram_raddr = cnt_reg;
        unique case (state_reg)
            ST_FILL: begin
                // identity fill
                ram_we = 1'b1;
            end
            ST_DRAW: begin
                // fetch table[i] while the modulo runs
                ram_re = 1'b1;
            end
            ST_MOD: begin
                if (mod_done) begin
                    ram_re    = 1'b1;
                    ram_raddr = swap_addr;
                end
            end
            ST_WR_I: begin
                // table[i] <= table[r]
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_WR_R: begin
                // table[r] <= old table[i]
                ram_we    = 1'b1;
                ram_waddr = r_reg;
                ram_wdata = t_reg;
            end
            ST_LOOKUP: begin
                ram_re    = 1'b1;
                ram_raddr = next_slot_reg[IDX_W-1:0];
            end
            ST_IDLE, ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (shuffle_req && need_rebuild) begin
                        state_next = ST_FILL;
                    end else if (shuffle_req) begin
                        state_next = ST_LOOKUP;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FILL: begin
                if (LEN_W'(cnt_reg) == stored_len_reg - LEN_W'(1)) begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: state_next = ST_MOD;
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_WR_I;
                end
            end
            ST_WR_I: state_next = ST_WR_R;
            ST_WR_R: begin
                if (LEN_W'(cnt_reg) == stored_len_reg - LEN_W'(2)) begin
                    state_next = ST_LOOKUP;
                end else begin
                    state_next = ST_DRAW;
                end
            end
            ST_LOOKUP: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            shuffle_en_reg <= 1'b0;
            seed_reg       <= sog_pkg::SEED_RESET;
            lfsr_reg       <= sog_pkg::SEED_RESET;
            stored_len_reg <= '0;
            next_slot_reg  <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration writes win; the user must issue them only while idle (not enforced)
            if (cfg_wr) begin
                unique case (sog_pkg::reg_idx_t'(paddr[2]))
                    sog_pkg::REG_SHUFFLE_ENABLE: shuffle_en_reg <= pwdata[0];
                    sog_pkg::REG_RANDOM_SEED: begin
                        seed_reg <= pwdata;
                        // a zero seed would lock the LFSR up
                        lfsr_reg <= (pwdata != 32'd0) ? pwdata : sog_pkg::SEED_RESET;
                    end
                endcase
            end else if (state_reg == ST_DRAW) begin
                lfsr_reg <= lfsr_step;
            end

            // rebuild bookkeeping
            if (in_acc && shuffle_req && need_rebuild) begin
                stored_len_reg <= len_c;
                next_slot_reg  <= '0;
                cnt_reg        <= '0;
            end else if (state_reg == ST_FILL) begin
                if (LEN_W'(cnt_reg) == stored_len_reg - LEN_W'(1)) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end else if (state_reg == ST_WR_R) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (state_reg == ST_LOOKUP) begin
                // advance to the next permuted slot
                next_slot_reg <= next_slot_reg + 1'b1;
            end

            // output register: drop on take, load from the finished item
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            from_table_reg <= shuffle_req;
            fresh_reg      <= shuffle_req && need_rebuild;
            seq_idx_reg    <= seq_idx;
        end
        // hold old table[i] for the second half of the swap
        if (state_reg == ST_MOD) begin
            t_reg <= ram_rdata;
        end
        if (state_reg == ST_MOD && mod_done) begin
            r_reg <= swap_addr;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_payload_reg.next_index <= from_table_reg ? 8'(ram_rdata) : seq_idx_reg;
            m_payload_reg.reshuffled <= fresh_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_draw_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAW) |-> (LEN_W'(cnt_reg) + LEN_W'(2) <= stored_len_reg))
        else $error("swap index beyond the last swap of the rebuild");

    a_mod_done_in_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == ST_MOD))
        else $error("modulo result arrived outside the modulo wait");

    a_swap_target_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_R) |-> (r_reg >= cnt_reg) &&
                                    (LEN_W'(r_reg) < stored_len_reg))
        else $error("swap target outside the remaining span");

    a_lookup_slot_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP) |-> (next_slot_reg < stored_len_reg))
        else $error("lookup past the end of the permutation");

    a_fresh_starts_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOKUP) && fresh_reg |-> (next_slot_reg == '0))
        else $error("rebuilt permutation not served from its first slot");

endmodule

/* src/sog_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module sog_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sog_mod.sv */
// Bit-serial restoring modulo unit: remainder of a random draw by the remaining span.
module sog_mod #(
    parameter int DIV_W = 9
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sog_pkg::DRAW_W-1:0]  dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic [DIV_W-1:0]            remainder
);

    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [sog_pkg::DRAW_W-1:0] dvd_reg;
    logic [DIV_W-1:0]           div_reg;
    logic [sog_pkg::STEP_W-1:0] step_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [DIV_W:0]             shifted;

    // Shift in one dividend bit, subtract the divisor when it fits
    always_comb begin
        shifted = {rem_reg, dvd_reg[sog_pkg::DRAW_W-1]};
        if (shifted >= {1'b0, div_reg}) begin
            rem_next = DIV_W'(shifted - {1'b0, div_reg});
        end else begin
            rem_next = DIV_W'(shifted);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= sog_pkg::STEP_W'(sog_pkg::DRAW_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == sog_pkg::STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[sog_pkg::DRAW_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* tb/tb_shuffle_order_generator.sv */
// Testbench for the shuffle order generator: directed table, random playlists, self-checking.
module tb_shuffle_order_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_MAX     = 256;
    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 6;
    localparam int          RANDOM_ITEMS = 1850;
    localparam int          NUM_PHASES   = 8;
    localparam int          HOLD_CYCLES  = 600;
    localparam int          RUSH_ITEMS   = 100;
    localparam int          DRAIN_CYCLES = 100;
    // Bound: every item (with playlist overrun) forcing a full-length rebuild after the longest
    // gaps on both sides, then some slack on top.
    localparam int unsigned CYCLE_LIMIT  = 3 * (RANDOM_ITEMS + 1000) * (20 * LIST_MAX + 40);
    localparam int          PLAN_ROWS    = 27;

    // Kinds of rows in the directed table
    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    // Item rows: a = list_length, b = current_index.
    // Write rows: a = register index, b = value.
    // When typed is set, want is the expected result; otherwise the predictor decides.
    typedef struct packed {
        row_kind_t          kind;
        logic [31:0]        a;
        logic [31:0]        b;
        logic               typed;
        sog_pkg::out_item_t want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    sog_pkg::in_item_t  s_payload;
    logic               m_valid;
    logic               m_ready;
    sog_pkg::out_item_t m_payload;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    shuffle_order_generator #(
        .LIST_MAX (LIST_MAX)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: own copy of the permutation, its bookkeeping, the
    // LFSR and the two registers.
    // ------------------------------------------------------------------
    logic [7:0]  play_order [LIST_MAX];
    int unsigned order_len;
    int unsigned order_slot;
    logic [31:0] lfsr_state;
    logic        shuffle_on;

    // Expected results, oldest first
    sog_pkg::out_item_t pending_picks [$];

    int unsigned error_count;
    int unsigned results_seen;
    int unsigned items_sent;
    int unsigned cycle_count;

    // Stimulus shaping flags shared between processes
    bit          tight;       // no idling on either side
    bit          hold_req;    // ask the receiver for one long hold-off
    int unsigned rush_left;   // items the sender offers back to back
    bit          valid_up;    // s_valid is currently driven high

    // Directed table: sequential rule after reset, extremes, short lists in
    // shuffled mode, zero and all-ones seeds, oversized length, and a mode
    // switch that must leave the permutation untouched.
    plan_row_t directed_plan [PLAN_ROWS] = '{
        // sequential mode straight out of reset
        '{ROW_ITEM,  32'd1,   32'd0,   1'b1, {8'd0,   1'b0}},
        '{ROW_ITEM,  32'd0,   32'd5,   1'b1, {8'd0,   1'b0}},   // zero length
        '{ROW_ITEM,  32'd256, 32'd254, 1'b1, {8'd255, 1'b0}},
        '{ROW_ITEM,  32'd256, 32'd255, 1'b1, {8'd0,   1'b0}},
        '{ROW_ITEM,  32'd511, 32'd255, 1'b1, {8'd0,   1'b0}},   // oversized, clamps
        '{ROW_ITEM,  32'd300, 32'd100, 1'b1, {8'd101, 1'b0}},
        '{ROW_ITEM,  32'd10,  32'd200, 1'b1, {8'd0,   1'b0}},   // index past the list
        '{ROW_WRITE, 32'(sog_pkg::REG_SHUFFLE_ENABLE), 32'd1, 1'b0, 9'd0},
        // lengths of two or less stay sequential
        '{ROW_ITEM,  32'd1,   32'd0,   1'b1, {8'd0,   1'b0}},
        '{ROW_ITEM,  32'd2,   32'd0,   1'b1, {8'd1,   1'b0}},
        '{ROW_ITEM,  32'd2,   32'd1,   1'b1, {8'd0,   1'b0}},
        '{ROW_ITEM,  32'd0,   32'd7,   1'b1, {8'd0,   1'b0}},
        // first shuffle from the reset seed, used up, then rebuilt
        '{ROW_ITEM,  32'd3,   32'd0,   1'b0, 9'd0},
        '{ROW_ITEM,  32'd3,   32'd85,  1'b0, 9'd0},
        '{ROW_ITEM,  32'd3,   32'd170, 1'b0, 9'd0},
        '{ROW_ITEM,  32'd3,   32'd255, 1'b0, 9'd0},
        '{ROW_WRITE, 32'(sog_pkg::REG_RANDOM_SEED), 32'd0, 1'b0, 9'd0},     // zero seed
        '{ROW_ITEM,  32'd4,   32'd0,   1'b0, 9'd0},
        '{ROW_ITEM,  32'd4,   32'd0,   1'b0, 9'd0},
        '{ROW_WRITE, 32'(sog_pkg::REG_RANDOM_SEED), 32'hFFFF_FFFF, 1'b0, 9'd0},
        '{ROW_ITEM,  32'd300, 32'd0,   1'b0, 9'd0},             // full-size rebuild
        '{ROW_ITEM,  32'd256, 32'd255, 1'b0, 9'd0},             // same length, no rebuild
        '{ROW_WRITE, 32'(sog_pkg::REG_SHUFFLE_ENABLE), 32'd0, 1'b0, 9'd0},
        '{ROW_ITEM,  32'd5,   32'd4,   1'b1, {8'd0,   1'b0}},
        '{ROW_ITEM,  32'd256, 32'd128, 1'b1, {8'd129, 1'b0}},
        '{ROW_WRITE, 32'(sog_pkg::REG_SHUFFLE_ENABLE), 32'd1, 1'b0, 9'd0},
        '{ROW_ITEM,  32'd256, 32'd0,   1'b0, 9'd0}              // resume the old order
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Advance the Galois LFSR one step and return its low draw bits.
    function automatic logic [sog_pkg::DRAW_W-1:0] next_draw();
        logic lsb;
        lsb        = lfsr_state[0];
        lfsr_state = lfsr_state >> 1;
        if (lsb) begin
            lfsr_state = lfsr_state ^ sog_pkg::LFSR_TAPS;
        end
        return lfsr_state[sog_pkg::DRAW_W-1:0];
    endfunction

    // Fisher-Yates over 0..n-1, one draw per swap.
    function automatic void rebuild_order(int unsigned n);
        int unsigned i;
        int unsigned r;
        int unsigned d;
        logic [7:0]  t;
        order_len  = n;
        order_slot = 0;
        for (i = 0; i < n; i++) begin
            play_order[i] = i[7:0];
        end
        for (i = 0; i + 1 < n; i++) begin
            d             = 32'(next_draw());
            r             = i + (d % (n - i));
            t             = play_order[i];
            play_order[i] = play_order[r];
            play_order[r] = t;
        end
    endfunction

    // Work out the next index to play and update the predictor state.
    function automatic sog_pkg::out_item_t predict_next_index(sog_pkg::in_item_t req);
        int unsigned        n;
        int unsigned        nxt;
        sog_pkg::out_item_t res;
        n = 32'(req.list_length);
        if (n > LIST_MAX) begin
            n = LIST_MAX;
        end
        res.reshuffled = 1'b0;
        if (shuffle_on && n > 2) begin
            if (n != order_len || order_slot >= order_len) begin
                rebuild_order(n);
                res.reshuffled = 1'b1;
            end
            nxt = 32'(play_order[order_slot]);
            order_slot++;
        end else begin
            nxt = 32'(req.current_index) + 1;
            if (nxt >= n) begin
                nxt = 0;
            end
        end
        res.next_index = nxt[7:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever begin
            #CLK_HALF aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR cycle limit of %0d reached with %0d results pending",
                     CYCLE_LIMIT, pending_picks.size());
            $display("tb_shuffle_order_generator failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        error_count++;
    endtask

    sog_pkg::out_item_t oldest_pick;

    // Compare each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_picks.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_payload), 32'd0);
            end else begin
                oldest_pick = pending_picks.pop_front();
                if (m_payload.next_index !== oldest_pick.next_index) begin
                    report_mismatch("next_index", 32'(m_payload.next_index),
                                    32'(oldest_pick.next_index));
                end
                if (m_payload.reshuffled !== oldest_pick.reshuffled) begin
                    report_mismatch("reshuffled", 32'(m_payload.reshuffled),
                                    32'(oldest_pick.reshuffled));
                end
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls per item, one long hold-off on request.
    // The stall is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        forever begin
            stall = tight ? 0 : $urandom_range(0, 19);
            if (hold_req) begin
                hold_req = 1'b0;
                stall    = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            // hold ready until one item moves
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request after a random gap; queue its expected result.
    task automatic send_item(input sog_pkg::in_item_t req, input bit typed,
                             input sog_pkg::out_item_t typed_out,
                             output sog_pkg::out_item_t pred);
        int unsigned gap;
        gap = (tight || rush_left > 0) ? 0 : $urandom_range(0, 19);
        if (rush_left > 0) begin
            rush_left--;
        end
        if (gap > 0) begin
            // drop valid for the gap, then raise it with the new item
            if (valid_up) begin
                s_valid <= 1'b0;
            end
            valid_up = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pred = predict_next_index(req);
        pending_picks.push_back(typed ? typed_out : pred);
        s_valid   <= 1'b1;
        s_payload <= req;
        valid_up   = 1'b1;
        items_sent++;
        // hold valid and payload until accepted
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every expected result has come.
    task automatic wait_drained();
        if (valid_up) begin
            s_valid <= 1'b0;
            valid_up = 1'b0;
            @(posedge aclk);
        end
        while (pending_picks.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // APB write, then read back: setup cycle, then access until pready.
    // Call only when drained.
    task automatic reg_write(input sog_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] want_rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // mirror the write in the predictor; a zero seed loads as one
        if (idx == sog_pkg::REG_SHUFFLE_ENABLE) begin
            shuffle_on = value[0];
            want_rd    = {31'd0, value[0]};
        end else begin
            lfsr_state = (value == 32'd0) ? sog_pkg::SEED_RESET : value;
            want_rd    = value;
        end
        // read the register back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want_rd) begin
            report_mismatch("register readback", prdata, want_rd);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // One playlist: a length held for a run of requests, fed back the
    // predicted index, with some noise items that break the sequence.
    task automatic run_playlist();
        int unsigned        len;
        int unsigned        count;
        int unsigned        cur;
        int unsigned        pick;
        int unsigned        k;
        sog_pkg::in_item_t  req;
        sog_pkg::out_item_t pred;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            len = $urandom_range(0, 2);
        end else if (pick < 85) begin
            len = $urandom_range(3, 16);
        end else if (pick < 97) begin
            len = $urandom_range(17, 64);
        end else begin
            len = $urandom_range(65, 511);
        end
        // long lists are costly to rebuild: keep their runs short
        count = (len > 64) ? $urandom_range(1, 40) : $urandom_range(1, 2 * len + 3);
        cur   = $urandom_range(0, 255);
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                req.list_length   = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                                                : 9'($urandom_range(0, 15));
                req.current_index = 8'($urandom_range(0, 255));
            end else begin
                req.list_length   = 9'(len);
                req.current_index = 8'(cur);
            end
            send_item(req, 1'b0, '0, pred);
            cur = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                              : 32'(pred.next_index);
        end
        // now and then pause the sender until the block has caught up
        if ($urandom_range(0, 9) == 0) begin
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_flow
        int unsigned        row_i;
        int unsigned        phase;
        int unsigned        random_start;
        int unsigned        phase_start;
        int unsigned        target;
        bit                 hold_done;
        bit                 en;
        logic [31:0]        seed;
        sog_pkg::in_item_t  req;
        sog_pkg::out_item_t pred;

        error_count  = 0;
        results_seen = 0;
        items_sent   = 0;
        cycle_count  = 0;
        tight        = 1'b0;
        hold_req     = 1'b0;
        rush_left    = 0;
        valid_up     = 1'b0;
        hold_done    = 1'b0;

        // drive every input to a known value and hold reset
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;

        // predictor reset state
        shuffle_on = 1'b0;
        lfsr_state = sog_pkg::SEED_RESET;
        order_len  = 0;
        order_slot = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table; register writes only once drained
        for (row_i = 0; row_i < PLAN_ROWS; row_i++) begin
            if (directed_plan[row_i].kind == ROW_WRITE) begin
                wait_drained();
                reg_write(sog_pkg::reg_idx_t'(directed_plan[row_i].a[0]),
                          directed_plan[row_i].b);
            end else begin
                req.list_length   = directed_plan[row_i].a[8:0];
                req.current_index = directed_plan[row_i].b[7:0];
                send_item(req, directed_plan[row_i].typed, directed_plan[row_i].want, pred);
            end
        end

        // random phases, each with its own register setting
        random_start = items_sent;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            tight = (phase == 2 || phase == 5);
            unique case (phase)
                0: begin
                    en   = 1'b1;
                    seed = sog_pkg::SEED_RESET;
                end
                1: begin
                    en   = 1'b0;
                    seed = '0;
                end
                2: begin
                    en   = 1'b1;
                    seed = 32'hFFFF_FFFF;
                end
                3: begin
                    en   = 1'b1;
                    seed = 32'd0;
                end
                default: begin
                    en   = ($urandom_range(0, 3) != 0);
                    seed = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
                end
            endcase
            reg_write(sog_pkg::REG_SHUFFLE_ENABLE, {31'd0, en});
            // the sequential phase keeps the old seed
            if (phase != 1) begin
                reg_write(sog_pkg::REG_RANDOM_SEED, seed);
            end
            phase_start = items_sent;
            target      = random_start + (phase + 1) * RANDOM_ITEMS / NUM_PHASES;
            while (items_sent < target) begin
                // one long receiver hold-off while the sender rushes items
                if (phase == 1 && !hold_done && items_sent >= phase_start + 40) begin
                    hold_done = 1'b1;
                    hold_req  = 1'b1;
                    rush_left = RUSH_ITEMS;
                end
                run_playlist();
            end
        end
        tight = 1'b0;

        // drain, then let a few more cycles pass to catch stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_picks.size() != 0) begin
            $display("ERROR %0d expected results never arrived", pending_picks.size());
            error_count++;
        end

        if (error_count == 0) begin
            $display("tb_shuffle_order_generator passed");
        end else begin
            $display("tb_shuffle_order_generator failed");
        end
        $finish;
    end

endmodule
